/* hw/rtl/non_restoring_divider_assert.svh */
// Assertion helpers for the checker file nrd_chk.sv.
`ifndef NON_RESTORING_DIVIDER_ASSERT_SVH
`define NON_RESTORING_DIVIDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define NRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/nrd_pkg.sv */
`default_nettype none
package nrd_pkg;

    // Width of each operand and result field on the stream ports.
    localparam int FIELD_W     = 16;
    localparam int TDATA_W     = 2 * FIELD_W;
    localparam int DEF_WIDTH   = 16;

    // Control that travels with every pipeline slot.
    typedef struct packed {
        logic valid;
        logic div_by_zero;
    } t_slot_ctl;

endpackage
`default_nettype wire

/* hw/rtl/non_restoring_divider.sv */
`default_nettype none
// Unsigned non-restoring divider, fully pipelined. Each transaction on the
// slave stream carries a dividend and a divisor; each transaction on the
// master stream carries the quotient, the remainder and, in tuser, a flag
// set when the divisor was zero (then the quotient is all ones and the
// remainder equals the dividend). One division enters per cycle while the
// output is not stalled. Each result passes one register stage per quotient
// bit, each holding a single (WIDTH+1)-bit add/subtract, plus one stage for
// the final remainder correction, which also serves as the output register.
// The whole pipeline holds while a result waits at the output, so
// s_axis_tready is high whenever the output slot is empty or being taken.
// Operand bits from WIDTH upward are ignored; results wider than 16 bits are
// truncated and narrower ones zero-extended.
module non_restoring_divider #(
    parameter int WIDTH = nrd_pkg::DEF_WIDTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] dividend, [31:16] divisor
    input  wire [nrd_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [15:0] quotient, [31:16] remainder
    output logic [nrd_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [0] div_by_zero
    output logic                         m_axis_tuser
);
    import nrd_pkg::*;

    // Operand fields, widened so that any WIDTH can slice them.
    logic [FIELD_W+WIDTH-1:0] dividend_wide;
    logic [FIELD_W+WIDTH-1:0] divisor_wide;
    logic [FIELD_W+WIDTH-1:0] quot_wide;
    logic [FIELD_W+WIDTH-1:0] rem_wide;

    // Pipeline slots: index 0 is the entry, index k the output of round k.
    t_slot_ctl        ctl [0:WIDTH];
    logic [WIDTH:0]   acc [0:WIDTH];
    logic [WIDTH-1:0] q   [0:WIDTH];
    logic [WIDTH-1:0] m   [0:WIDTH];

    t_slot_ctl        out_ctl;
    logic [WIDTH-1:0] out_quot;
    logic [WIDTH-1:0] out_rem;
    logic             advance;

    // Advance every stage together unless a finished result is stalled.
    assign advance       = !out_ctl.valid || m_axis_tready;
    assign s_axis_tready = advance;

    assign dividend_wide = {{WIDTH{1'b0}}, s_axis_tdata[FIELD_W-1:0]};
    assign divisor_wide  = {{WIDTH{1'b0}}, s_axis_tdata[TDATA_W-1:FIELD_W]};

    // Entry slot: empty partial remainder, dividend in the quotient register.
    assign ctl[0] = '{valid:       s_axis_tvalid,
                      div_by_zero: (divisor_wide[WIDTH-1:0] == '0)};
    assign acc[0] = '0;
    assign q[0]   = dividend_wide[WIDTH-1:0];
    assign m[0]   = divisor_wide[WIDTH-1:0];

    // One stage per quotient bit, most significant first.
    for (genvar k = 0; k < WIDTH; k++) begin : g_round
        nrd_stage #(
            .W (WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_ctl   (ctl[k]),
            .i_acc   (acc[k]),
            .i_q     (q[k]),
            .i_m     (m[k]),
            .o_ctl   (ctl[k+1]),
            .o_acc   (acc[k+1]),
            .o_q     (q[k+1]),
            .o_m     (m[k+1])
        );
    end

    // Remainder correction and output register.
    nrd_fix #(
        .W (WIDTH)
    ) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (ctl[WIDTH]),
        .i_acc   (acc[WIDTH]),
        .i_q     (q[WIDTH]),
        .i_m     (m[WIDTH]),
        .o_ctl   (out_ctl),
        .o_quot  (out_quot),
        .o_rem   (out_rem)
    );

    // With a zero divisor the rounds already give all ones and the dividend.
    assign quot_wide = {{FIELD_W{1'b0}}, out_quot};
    assign rem_wide  = {{FIELD_W{1'b0}}, out_rem};

    assign m_axis_tvalid = out_ctl.valid;
    assign m_axis_tdata  = {rem_wide[FIELD_W-1:0], quot_wide[FIELD_W-1:0]};
    assign m_axis_tuser  = out_ctl.div_by_zero;

endmodule
`default_nettype wire

/* hw/rtl/nrd_stage.sv */
`default_nettype none
module nrd_stage #(
    parameter int W = nrd_pkg::DEF_WIDTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire nrd_pkg::t_slot_ctl i_ctl,
    input  wire [W:0]           i_acc,
    input  wire [W-1:0]         i_q,
    input  wire [W-1:0]         i_m,
    output nrd_pkg::t_slot_ctl  o_ctl,
    output logic [W:0]          o_acc,
    output logic [W-1:0]        o_q,
    output logic [W-1:0]        o_m
);
    import nrd_pkg::*;

    logic [W:0]   n_shift;
    logic [W:0]   n_acc;
    logic [W-1:0] n_q;
    logic         r_valid;
    logic         r_dz;
    logic [W:0]   r_acc;
    logic [W-1:0] r_q;
    logic [W-1:0] r_m;

    // Shift in the next dividend bit, then add or subtract by the old sign.
    always_comb begin
        n_shift = {i_acc[W-1:0], i_q[W-1]};
        if (i_acc[W]) begin
            n_acc = n_shift + {1'b0, i_m};
        end else begin
            n_acc = n_shift - {1'b0, i_m};
        end
        n_q = {i_q[W-2:0], ~n_acc[W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dz  <= i_ctl.div_by_zero;
            r_acc <= n_acc;
            r_q   <= n_q;
            r_m   <= i_m;
        end
    end

    assign o_ctl = '{valid: r_valid, div_by_zero: r_dz};
    assign o_acc = r_acc;
    assign o_q   = r_q;
    assign o_m   = r_m;

endmodule
`default_nettype wire

/* hw/rtl/nrd_fix.sv */
`default_nettype none
module nrd_fix #(
    parameter int W = nrd_pkg::DEF_WIDTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire nrd_pkg::t_slot_ctl i_ctl,
    input  wire [W:0]           i_acc,
    input  wire [W-1:0]         i_q,
    input  wire [W-1:0]         i_m,
    output nrd_pkg::t_slot_ctl  o_ctl,
    output logic [W-1:0]        o_quot,
    output logic [W-1:0]        o_rem
);
    import nrd_pkg::*;

    logic [W:0]   n_rem;
    logic         r_valid;
    logic         r_dz;
    logic [W-1:0] r_quot;
    logic [W-1:0] r_rem;

    // Add the divisor back once when the last partial remainder is negative.
    always_comb begin
        if (i_acc[W]) begin
            n_rem = i_acc + {1'b0, i_m};
        end else begin
            n_rem = i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dz   <= i_ctl.div_by_zero;
            r_quot <= i_q;
            r_rem  <= n_rem[W-1:0];
        end
    end

    assign o_ctl  = '{valid: r_valid, div_by_zero: r_dz};
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

/* hw/rtl/nrd_chk.sv */
`default_nettype none
`include "non_restoring_divider_assert.svh"
module nrd_chk #(
    parameter int WIDTH = nrd_pkg::DEF_WIDTH
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         s_axis_tready,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [nrd_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire                         m_axis_tuser
);
    import nrd_pkg::*;

    localparam logic [FIELD_W+WIDTH-1:0] ONES_WIDE = {{FIELD_W{1'b0}}, {WIDTH{1'b1}}};
    localparam logic [FIELD_W-1:0]       QUOT_ONES = ONES_WIDE[FIELD_W-1:0];

    logic               out_stall;
    logic               out_dz;
    logic [TDATA_W:0]   out_word;
    logic [FIELD_W-1:0] out_quot;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_dz    = m_axis_tvalid && m_axis_tuser;
    assign out_word  = {m_axis_tuser, m_axis_tdata};
    assign out_quot  = m_axis_tdata[FIELD_W-1:0];

    // A stalled result holds.
    `NRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // Input side moves exactly when the output slot is free or drains.
    `NRD_ASSERT_SAME(a_ready_link, i_clk, i_rst_n, 1'b1, s_axis_tready == !out_stall)

    // A zero divisor always reports an all-ones quotient.
    `NRD_ASSERT_SAME(a_dz_quot, i_clk, i_rst_n, out_dz, out_quot == QUOT_ONES)

endmodule

bind non_restoring_divider nrd_chk #(
    .WIDTH (WIDTH)
) u_nrd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
